/* rtl/pla_pkg.sv */
// ----------------------------------------------------------------------------
// pla_pkg
// Shared sizes, codes and controller/datapath bundles of the priority lock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pla_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 6;
  localparam int PRIO_BITS   = 8;

  // waiter table address, also wide enough for an arrival rank
  localparam int AW = $clog2(QUEUE_DEPTH);
  // waiter count, 0 .. QUEUE_DEPTH
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_PASSED    = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic [AW-1:0]        age;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic age_up;
    logic scan;
    logic age_down;
  } cmd_t;

  typedef struct packed {
    logic queue;
    logic pass;
    logic sweep_last;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/pla_ctrl.sv */
// ----------------------------------------------------------------------------
// pla_ctrl
// Sequencer of the priority lock: picks the table sweeps a request needs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pla_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pla_pkg::stat_t  stat,
  output logic            busy,
  output pla_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_AGE_UP   = 4'b0010,
    S_SCAN     = 4'b0100,
    S_AGE_DOWN = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (stat.queue) begin
            state_next = S_AGE_UP;
          end else if (stat.pass) begin
            state_next = S_SCAN;
          end
        end
      end
      S_AGE_UP: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.sweep_last) state_next = S_AGE_DOWN;
      end
      S_AGE_DOWN: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy         = (state != S_IDLE);
  assign cmd.accept   = start && (state == S_IDLE);
  assign cmd.age_up   = (state == S_AGE_UP);
  assign cmd.scan     = (state == S_SCAN);
  assign cmd.age_down = (state == S_AGE_DOWN);

endmodule

`default_nettype wire

/* rtl/pla_datapath.sv */
// ----------------------------------------------------------------------------
// pla_datapath
// Lock state, waiter table memory with its sweep pipeline, and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pla_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  pla_pkg::cmd_t                  cmd,
  output pla_pkg::stat_t                 stat,
  input  logic                           operation,
  input  logic [pla_pkg::ID_BITS-1:0]    requester_id,
  input  logic [pla_pkg::PRIO_BITS-1:0]  priority_req,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [pla_pkg::ID_BITS-1:0]    new_owner,
  output logic                           lock_held
);

  logic                            held;
  logic [pla_pkg::ID_BITS-1:0]     owner;
  logic [pla_pkg::QUEUE_DEPTH-1:0] valid;
  logic [pla_pkg::CW-1:0]          count;

  logic [pla_pkg::ID_BITS-1:0]     req_id;
  logic [pla_pkg::PRIO_BITS-1:0]   req_prio;

  pla_pkg::entry_t                 mem [pla_pkg::QUEUE_DEPTH];
  pla_pkg::entry_t                 rd_q;
  logic [pla_pkg::CW-1:0]          cnt;
  logic                            p_vld;
  logic [pla_pkg::AW-1:0]          p_addr;
  logic                            placed;
  logic                            found;
  logic [pla_pkg::AW-1:0]          best_idx;
  pla_pkg::entry_t                 best;

  logic                            sweep_on;
  logic                            issue;
  logic                            last;
  logic                            is_full;
  logic                            is_empty;
  logic                            is_owner;
  logic                            better;
  logic                            mem_we;
  pla_pkg::entry_t                 mem_wd;

  assign sweep_on = cmd.age_up || cmd.scan || cmd.age_down;
  assign issue    = sweep_on && (cnt < pla_pkg::CW'(pla_pkg::QUEUE_DEPTH));
  assign last     = p_vld && (p_addr == pla_pkg::AW'(pla_pkg::QUEUE_DEPTH - 1));
  assign is_full  = (count == pla_pkg::CW'(pla_pkg::QUEUE_DEPTH));
  assign is_empty = (count == '0);
  assign is_owner = held && (owner == requester_id);

  assign stat.queue      = (operation == pla_pkg::OP_ACQUIRE) && held && !is_full;
  assign stat.pass       = (operation == pla_pkg::OP_RELEASE) && is_owner && !is_empty;
  assign stat.sweep_last = last;

  // higher priority wins, on a tie the younger arrival
  assign better = valid[p_addr] &&
                  (!found || (rd_q.prio > best.prio) ||
                   ((rd_q.prio == best.prio) && (rd_q.age < best.age)));

  always_comb begin
    mem_we = 1'b0;
    mem_wd = rd_q;
    if (p_vld && cmd.age_up) begin
      if (valid[p_addr]) begin
        mem_we     = 1'b1;
        mem_wd.age = rd_q.age + 1'b1;
      end else if (!placed) begin
        mem_we      = 1'b1;
        mem_wd.id   = req_id;
        mem_wd.prio = req_prio;
        mem_wd.age  = '0;
      end
    end
    if (p_vld && cmd.age_down && valid[p_addr] && (rd_q.age > best.age)) begin
      mem_we     = 1'b1;
      mem_wd.age = rd_q.age - 1'b1;
    end
  end

  // read at the sweep counter, write back in the next cycle at the same entry
  always_ff @(posedge clk) begin
    if (mem_we) mem[p_addr] <= mem_wd;
    if (issue) begin
      rd_q   <= mem[cnt[pla_pkg::AW-1:0]];
      p_addr <= cnt[pla_pkg::AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= 1'b0;
      owner  <= '0;
      valid  <= '0;
      count  <= '0;
      cnt    <= '0;
      p_vld  <= 1'b0;
      placed <= 1'b0;
      found  <= 1'b0;
      done   <= 1'b0;
    end else begin
      done  <= 1'b0;
      p_vld <= issue;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end else if (last) begin
        cnt <= '0;
      end
      if (cmd.accept) begin
        placed <= 1'b0;
        found  <= 1'b0;
        done   <= !(stat.queue || stat.pass);
        if (operation == pla_pkg::OP_ACQUIRE) begin
          if (!held) begin
            held  <= 1'b1;
            owner <= requester_id;
          end
        end else if (is_owner && is_empty) begin
          held  <= 1'b0;
          owner <= '0;
        end
      end
      if (p_vld && cmd.age_up && !valid[p_addr] && !placed) begin
        valid[p_addr] <= 1'b1;
        placed        <= 1'b1;
      end
      if (p_vld && cmd.scan && better) found <= 1'b1;
      if (last && cmd.age_up) begin
        count <= count + 1'b1;
        done  <= 1'b1;
      end
      if (last && cmd.age_down) begin
        count           <= count - 1'b1;
        valid[best_idx] <= 1'b0;
        owner           <= best.id;
        done            <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_id   <= requester_id;
      req_prio <= priority_req;
      if (operation == pla_pkg::OP_ACQUIRE) begin
        lock_held <= 1'b1;
        if (!held) begin
          status    <= pla_pkg::ST_GRANTED;
          new_owner <= requester_id;
        end else begin
          status    <= is_full ? pla_pkg::ST_FULL : pla_pkg::ST_QUEUED;
          new_owner <= owner;
        end
      end else if (!is_owner) begin
        status    <= pla_pkg::ST_NOT_OWNER;
        new_owner <= held ? owner : '0;
        lock_held <= held;
      end else begin
        status    <= pla_pkg::ST_FREED;
        new_owner <= '0;
        lock_held <= 1'b0;
      end
    end
    if (p_vld && cmd.scan && better) begin
      best_idx <= p_addr;
      best     <= rd_q;
    end
    if (last && cmd.age_up) begin
      status    <= pla_pkg::ST_QUEUED;
      new_owner <= owner;
      lock_held <= 1'b1;
    end
    if (last && cmd.age_down) begin
      status    <= pla_pkg::ST_PASSED;
      new_owner <= best.id;
      lock_held <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= pla_pkg::CW'(pla_pkg::QUEUE_DEPTH))
    else $error("waiter count out of range");

  // the new entry is marked valid mid-sweep, the count follows at its end
  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    !sweep_on |-> ($countones(valid) == count))
    else $error("waiter count disagrees with valid bits");

  a_free_empty: assert property (@(posedge clk) disable iff (rst)
    !held |-> is_empty)
    else $error("waiters present on a free lock");

  a_sweep_mode: assert property (@(posedge clk) disable iff (rst)
    p_vld |-> sweep_on)
    else $error("table read outside a sweep");

  a_pass_found: assert property (@(posedge clk) disable iff (rst)
    (last && cmd.age_down) |-> found)
    else $error("hand-over without a chosen waiter");
`endif

endmodule

`default_nettype wire

/* rtl/priority_lock_arbiter.sv */
// ----------------------------------------------------------------------------
// priority_lock_arbiter
// Priority lock with a waiter table; a release hands over to the best waiter.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     operation, requester_id, priority_req
//  result    done (strobe)    status, new_owner, lock_held
//
//  grant, full, not-owner and free requests: result in the cycle after the beat
//  acquire that queues: one age-up sweep of the table
//  release that hands over: a scan then an age-down sweep, both through the
//  one read port and one write port of the waiter memory
//  rst is synchronous and empties the table; busy is low in the result cycle
//  results cannot be stalled, each done lasts exactly one cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module priority_lock_arbiter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation,
  input  logic [pla_pkg::ID_BITS-1:0]    requester_id,
  input  logic [pla_pkg::PRIO_BITS-1:0]  priority_req,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [pla_pkg::ID_BITS-1:0]    new_owner,
  output logic                           lock_held
);

  pla_pkg::cmd_t  cmd;
  pla_pkg::stat_t stat;

  pla_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  pla_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .requester_id (requester_id),
    .priority_req (priority_req),
    .done         (done),
    .status       (status),
    .new_owner    (new_owner),
    .lock_held    (lock_held)
  );

endmodule

`default_nettype wire
